// File: sv/smt_pkg.sv
// Shared types and codes for the sorted multiset table.
// Used by smt_ctrl, smt_dp, sorted_multiset_table_unit, smt_result_checker and the testbench; depends on nothing.
package smt_pkg;

   // request modes
   localparam logic [2:0] MODE_INSERT     = 3'd0;
   localparam logic [2:0] MODE_DELETE     = 3'd1;
   localparam logic [2:0] MODE_REMOVE_MAX = 3'd2;
   localparam logic [2:0] MODE_READ_ASC   = 3'd3;
   localparam logic [2:0] MODE_READ_DESC  = 3'd4;
   localparam logic [2:0] MODE_CLEAR      = 3'd5;

   // response status codes
   localparam logic [3:0] ST_NEW       = 4'd0;
   localparam logic [3:0] ST_INCREMENT = 4'd1;
   localparam logic [3:0] ST_DECREMENT = 4'd2;
   localparam logic [3:0] ST_REMOVED   = 4'd3;
   localparam logic [3:0] ST_NOT_FOUND = 4'd4;
   localparam logic [3:0] ST_FULL      = 4'd5;
   localparam logic [3:0] ST_SATURATED = 4'd6;
   localparam logic [3:0] ST_ENTRY     = 4'd7;
   localparam logic [3:0] ST_EMPTY     = 4'd8;
   localparam logic [3:0] ST_CLEARED   = 4'd9;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CMP,
      S_UPD,
      S_READ
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;      // capture the request item
      logic cmp;       // register compare flags
      logic upd;       // apply the update, emit a single result
      logic rd_step;   // emit the next entry of a read
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;  // response register can take a new item
      logic rd_go;     // request is a read of a non-empty table
      logic rd_last;   // read index points at the final entry
   } sts_type;

endpackage

// File: sv/sorted_multiset_table_unit.sv
// Top level of the sorted multiset table: controller plus cell datapath.
// Depends on smt_pkg, smt_ctrl and smt_dp.
//
//   channel   direction  handshake              payload
//   req       in         req_valid/req_ready    req_mode, req_value
//   rsp       out        rsp_valid/rsp_ready    rsp_status, rsp_entry_value,
//                                               rsp_entry_count, rsp_last
//
// Insert, delete, remove-max and clear pass through accept, parallel compare
// in every cell, then a shift/update of the cells.
// Reads then stream the N stored entries, one entry per cycle while the response register is free.
// Synchronous reset empties the table; cell contents are not cleared.
// A stalled response holds the sequencer before the update or next read step.
module sorted_multiset_table_unit #(
   parameter int DEPTH      = 16,
   parameter int COUNT_BITS = 16,
   parameter int VALUE_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_mode,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [3:0]         rsp_status,
   output logic signed [31:0] rsp_entry_value,
   output logic [15:0]        rsp_entry_count,
   output logic               rsp_last
);
   import smt_pkg::*;

   cmd_type cmd;
   sts_type sts;

   smt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   smt_dp #(
      .DEPTH      (DEPTH),
      .COUNT_BITS (COUNT_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_mode        (req_mode),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_entry_value (rsp_entry_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_last        (rsp_last)
   );

endmodule

// File: sv/smt_ctrl.sv
// Sequencer for the sorted multiset table: accept, compare, update, stream.
// Depends on smt_pkg; drives the command struct of smt_dp.
module smt_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output smt_pkg::cmd_type cmd,
   input  smt_pkg::sts_type sts
);
   import smt_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
            if (req_valid) begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            cmd.cmp  = 1'b1;
            state_in = S_UPD;
         end
         S_UPD: begin
            // hold until the response register is free
            if (sts.out_free) begin
               cmd.upd  = 1'b1;
               state_in = sts.rd_go ? S_READ : S_IDLE;
            end
         end
         S_READ: begin
            if (sts.out_free) begin
               cmd.rd_step = 1'b1;
               if (sts.rd_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// File: sv/smt_dp.sv
// Datapath of the sorted multiset table: register cells with per-cell compare
// and neighbor shift, read index and response register. Depends on smt_pkg.
module smt_dp #(
   parameter int DEPTH      = 16,
   parameter int COUNT_BITS = 16,
   parameter int VALUE_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  smt_pkg::cmd_type    cmd,
   output smt_pkg::sts_type    sts,
   input  logic [2:0]          req_mode,
   input  logic signed [31:0]  req_value,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [3:0]          rsp_status,
   output logic signed [31:0]  rsp_entry_value,
   output logic [15:0]         rsp_entry_count,
   output logic                rsp_last
);
   import smt_pkg::*;

   localparam int OW = $clog2(DEPTH + 1);
   localparam int IW = $clog2(DEPTH);
   localparam int VB = VALUE_BITS;
   localparam int CB = COUNT_BITS;
   localparam logic [CB-1:0] CMAX = {CB{1'b1}};

   logic [2:0]           mode_ff;
   logic signed [VB-1:0] v_ff;
   logic signed [VB-1:0] v_norm;

   logic signed [VB-1:0] val_ff [DEPTH];
   logic signed [VB-1:0] val_in [DEPTH];
   logic [CB-1:0]        cnt_ff [DEPTH];
   logic [CB-1:0]        cnt_in [DEPTH];
   logic [OW-1:0]        occ_ff, occ_in;

   logic [DEPTH-1:0]     below_ff, below_c;
   logic [DEPTH-1:0]     eq_ff, eq_c;
   logic [CB-1:0]        hit_ff, hit_c;
   logic [IW-1:0]        rd_idx_ff;
   logic [IW-1:0]        rd_sel;
   logic [IW-1:0]        top_idx;

   logic                 found;
   logic                 at_full;
   logic                 rd_last;

   logic                 out_load;
   logic [3:0]           out_status_in;
   logic                 out_last_in;
   logic signed [VB-1:0] sel_val;
   logic [CB-1:0]        sel_cnt;
   logic signed [31:0]   sel_val32;
   logic [15:0]          sel_cnt16;

   logic                 rsp_valid_ff;
   logic [3:0]           rsp_status_ff;
   logic signed [31:0]   rsp_value_ff;
   logic [15:0]          rsp_count_ff;
   logic                 rsp_last_ff;

   // cut or sign-extend values in and out; cut or zero-fill the count
   generate
      if (VB <= 32) begin : g_vin_narrow
         assign v_norm = req_value[VB-1:0];
      end else begin : g_vin_wide
         assign v_norm = {{(VB-32){req_value[31]}}, req_value};
      end
      if (VB >= 32) begin : g_vout_wide
         assign sel_val32 = sel_val[31:0];
      end else begin : g_vout_narrow
         assign sel_val32 = {{(32-VB){sel_val[VB-1]}}, sel_val};
      end
      if (CB >= 16) begin : g_cout_wide
         assign sel_cnt16 = sel_cnt[15:0];
      end else begin : g_cout_narrow
         assign sel_cnt16 = {{(16-CB){1'b0}}, sel_cnt};
      end
   endgenerate

   // per-cell compare against the captured value
   always_comb begin
      hit_c = '0;
      for (int i = 0; i < DEPTH; i++) begin
         below_c[i] = (OW'(i) < occ_ff) && (val_ff[i] < v_ff);
         eq_c[i]    = (OW'(i) < occ_ff) && (val_ff[i] == v_ff);
         hit_c      = hit_c | (eq_c[i] ? cnt_ff[i] : '0);
      end
   end

   assign found   = |eq_ff;
   assign at_full = (occ_ff == OW'(DEPTH));
   assign top_idx = IW'(occ_ff - OW'(1));
   assign rd_last = ((OW'(rd_idx_ff) + OW'(1)) == occ_ff);
   assign rd_sel  = (mode_ff == MODE_READ_DESC) ? IW'(occ_ff - OW'(1) - OW'(rd_idx_ff))
                                                : rd_idx_ff;

   assign sts.out_free = !rsp_valid_ff || rsp_ready;
   assign sts.rd_go    = ((mode_ff == MODE_READ_ASC) || (mode_ff == MODE_READ_DESC))
                         && (occ_ff != '0);
   assign sts.rd_last  = rd_last;

   // cell updates and result selection
   always_comb begin
      val_in        = val_ff;
      cnt_in        = cnt_ff;
      occ_in        = occ_ff;
      out_load      = 1'b0;
      out_status_in = ST_NEW;
      out_last_in   = 1'b1;
      sel_val       = '0;
      sel_cnt       = '0;
      if (cmd.upd) begin
         case (mode_ff)
            MODE_INSERT: begin
               out_load = 1'b1;
               sel_val  = v_ff;
               if (found) begin
                  if (hit_ff == CMAX) begin
                     out_status_in = ST_SATURATED;
                     sel_cnt       = hit_ff;
                  end else begin
                     out_status_in = ST_INCREMENT;
                     sel_cnt       = hit_ff + CB'(1);
                     for (int i = 0; i < DEPTH; i++) begin
                        if (eq_ff[i]) begin
                           cnt_in[i] = cnt_ff[i] + CB'(1);
                        end
                     end
                  end
               end else if (at_full) begin
                  out_status_in = ST_FULL;
                  sel_cnt       = '0;
               end else begin
                  out_status_in = ST_NEW;
                  sel_cnt       = CB'(1);
                  occ_in        = occ_ff + OW'(1);
                  // open a slot at the first cell not below the value
                  if (!below_ff[0]) begin
                     val_in[0] = v_ff;
                     cnt_in[0] = CB'(1);
                  end
                  for (int i = 1; i < DEPTH; i++) begin
                     if (!below_ff[i]) begin
                        if (below_ff[i-1]) begin
                           val_in[i] = v_ff;
                           cnt_in[i] = CB'(1);
                        end else begin
                           val_in[i] = val_ff[i-1];
                           cnt_in[i] = cnt_ff[i-1];
                        end
                     end
                  end
               end
            end
            MODE_DELETE: begin
               out_load = 1'b1;
               sel_val  = v_ff;
               if (found) begin
                  if (hit_ff > CB'(1)) begin
                     out_status_in = ST_DECREMENT;
                     sel_cnt       = hit_ff - CB'(1);
                     for (int i = 0; i < DEPTH; i++) begin
                        if (eq_ff[i]) begin
                           cnt_in[i] = cnt_ff[i] - CB'(1);
                        end
                     end
                  end else begin
                     out_status_in = ST_REMOVED;
                     occ_in        = occ_ff - OW'(1);
                     // close the gap left by the matching cell
                     for (int i = 0; i < DEPTH - 1; i++) begin
                        if (!below_ff[i]) begin
                           val_in[i] = val_ff[i+1];
                           cnt_in[i] = cnt_ff[i+1];
                        end
                     end
                  end
               end else begin
                  out_status_in = ST_NOT_FOUND;
               end
            end
            MODE_REMOVE_MAX: begin
               out_load = 1'b1;
               if (occ_ff == '0) begin
                  out_status_in = ST_EMPTY;
               end else begin
                  out_status_in = ST_REMOVED;
                  sel_val       = val_ff[top_idx];
                  occ_in        = occ_ff - OW'(1);
               end
            end
            MODE_READ_ASC, MODE_READ_DESC: begin
               if (occ_ff == '0) begin
                  out_load      = 1'b1;
                  out_status_in = ST_EMPTY;
               end
            end
            MODE_CLEAR: begin
               out_load      = 1'b1;
               out_status_in = ST_CLEARED;
               occ_in        = '0;
            end
            default: begin
            end
         endcase
      end else if (cmd.rd_step) begin
         out_load      = 1'b1;
         out_status_in = ST_ENTRY;
         sel_val       = val_ff[rd_sel];
         sel_cnt       = cnt_ff[rd_sel];
         out_last_in   = rd_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      cnt_ff <= cnt_in;
      if (cmd.load) begin
         mode_ff <= req_mode;
         v_ff    <= v_norm;
      end
      if (cmd.cmp) begin
         below_ff <= below_c;
         eq_ff    <= eq_c;
         hit_ff   <= hit_c;
      end
      if (cmd.upd) begin
         rd_idx_ff <= '0;
      end else if (cmd.rd_step) begin
         rd_idx_ff <= rd_idx_ff + IW'(1);
      end
      if (out_load) begin
         rsp_status_ff <= out_status_in;
         rsp_value_ff  <= sel_val32;
         rsp_count_ff  <= sel_cnt16;
         rsp_last_ff   <= out_last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_value = rsp_value_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_last        = rsp_last_ff;

   // occupied cells must stay strictly ascending
   logic [DEPTH-1:0] order_bad;
   always_comb begin
      order_bad = '0;
      for (int i = 0; i < DEPTH - 1; i++) begin
         order_bad[i] = (OW'(i + 1) < occ_ff) && !(val_ff[i] < val_ff[i+1]);
      end
   end

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OW'(DEPTH))
      else $error("occupancy above depth");

   a_single_match: assert property (@(posedge clock) disable iff (reset)
      cmd.upd |-> $onehot0(eq_ff))
      else $error("more than one cell matches");

   a_sorted: assert property (@(posedge clock) disable iff (reset)
      order_bad == '0)
      else $error("cells out of order");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.upd && (mode_ff == MODE_CLEAR) |=> occ_ff == '0)
      else $error("clear left entries");

   a_read_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_step |-> occ_ff != '0)
      else $error("read step on empty table");

endmodule

// File: verif/smt_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the sorted multiset table: watches the req and rsp channels,
// predicts each response item from its own copy of the table and compares them.
// Depends on smt_pkg for the mode and status codes.
module smt_result_checker #(
   parameter int DEPTH      = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [2:0]         req_mode,
   input  logic signed [31:0] req_value,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [3:0]         rsp_status,
   input  logic signed [31:0] rsp_entry_value,
   input  logic [15:0]        rsp_entry_count,
   input  logic               rsp_last,
   output int                 error_count,
   output int                 pending_results
);
   import smt_pkg::*;

   localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 1;

   typedef struct packed {
      logic [3:0]         status;
      logic signed [31:0] value;
      logic [15:0]        count;
      logic               last;
   } table_result_type;

   logic signed [31:0] slot_value [DEPTH];
   longint unsigned    slot_count [DEPTH];
   int                 used_slots;
   table_result_type   expected_results [$];

   function automatic void push_result(logic [3:0] status, logic signed [31:0] value,
                                       longint unsigned count, logic last);
      table_result_type item;
      item.status = status;
      item.value  = value;
      item.count  = count[15:0];
      item.last   = last;
      expected_results.push_back(item);
   endfunction

   // Apply one request item to the shadow table and queue its response items.
   function automatic void predict_table_op(logic [2:0] mode, logic signed [31:0] operand);
      int pos;
      pos = 0;
      case (mode)
         MODE_INSERT: begin
            while (pos < used_slots && slot_value[pos] < operand)
               pos++;
            if (pos < used_slots && slot_value[pos] == operand) begin
               if (slot_count[pos] >= COUNT_MAX) begin
                  push_result(ST_SATURATED, operand, slot_count[pos], 1'b1);
               end else begin
                  slot_count[pos]++;
                  push_result(ST_INCREMENT, operand, slot_count[pos], 1'b1);
               end
            end else if (used_slots >= DEPTH) begin
               push_result(ST_FULL, operand, 0, 1'b1);
            end else begin
               for (int j = used_slots; j > pos; j--) begin
                  slot_value[j] = slot_value[j - 1];
                  slot_count[j] = slot_count[j - 1];
               end
               slot_value[pos] = operand;
               slot_count[pos] = 1;
               used_slots++;
               push_result(ST_NEW, operand, 1, 1'b1);
            end
         end
         MODE_DELETE: begin
            while (pos < used_slots && slot_value[pos] != operand)
               pos++;
            if (pos == used_slots) begin
               push_result(ST_NOT_FOUND, operand, 0, 1'b1);
            end else if (slot_count[pos] > 1) begin
               slot_count[pos]--;
               push_result(ST_DECREMENT, operand, slot_count[pos], 1'b1);
            end else begin
               // close the gap left by the removed entry
               for (int j = pos; j + 1 < used_slots; j++) begin
                  slot_value[j] = slot_value[j + 1];
                  slot_count[j] = slot_count[j + 1];
               end
               used_slots--;
               push_result(ST_REMOVED, operand, 0, 1'b1);
            end
         end
         MODE_REMOVE_MAX: begin
            if (used_slots == 0) begin
               push_result(ST_EMPTY, 0, 0, 1'b1);
            end else begin
               push_result(ST_REMOVED, slot_value[used_slots - 1], 0, 1'b1);
               used_slots--;
            end
         end
         MODE_READ_ASC, MODE_READ_DESC: begin
            if (used_slots == 0) begin
               push_result(ST_EMPTY, 0, 0, 1'b1);
            end else begin
               for (int k = 0; k < used_slots; k++) begin
                  pos = (mode == MODE_READ_ASC) ? k : used_slots - 1 - k;
                  push_result(ST_ENTRY, slot_value[pos], slot_count[pos], k == used_slots - 1);
               end
            end
         end
         MODE_CLEAR: begin
            used_slots = 0;
            push_result(ST_CLEARED, 0, 0, 1'b1);
         end
         default: ;  // unused modes: no response, no change
      endcase
   endfunction

   function automatic bit field_ok(string field_name, longint want, longint got);
      if (want == got)
         return 1'b1;
      $display("%0t: %s differs, expected %0d, actual %0d", $time, field_name, want, got);
      return 1'b0;
   endfunction

   always @(posedge clock) begin : monitor
      table_result_type want;
      bit               ok;
      if (reset) begin
         error_count = 0;
         used_slots  = 0;
         expected_results.delete();
      end else begin
         // retire the response first; a request accepted now cannot have answered yet
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: response item with none pending, expected none, actual %s",
                        $time, $sformatf("status %0d value %0d count %0d last %0d",
                        rsp_status, rsp_entry_value, rsp_entry_count, rsp_last));
               error_count++;
            end else begin
               want = expected_results.pop_front();
               ok = field_ok("status", want.status, rsp_status)
                  & field_ok("entry_value", want.value, rsp_entry_value)
                  & field_ok("entry_count", want.count, rsp_entry_count)
                  & field_ok("last", want.last, rsp_last);
               if (!ok)
                  error_count++;
            end
         end
         if (req_valid && req_ready)
            predict_table_op(req_mode, req_value);
      end
      pending_results = expected_results.size();
   end

endmodule

// File: verif/sorted_multiset_table_unit_test.sv
`timescale 1ns / 1ps
// Top of the sorted multiset table testbench: clock, reset, request and response
// stimulus, and the verdict. Depends on smt_pkg, sorted_multiset_table_unit and
// smt_result_checker.
module sorted_multiset_table_unit_test;
   import smt_pkg::*;

   localparam int TABLE_DEPTH     = 16;
   localparam int COUNT_WIDTH     = 16;
   localparam int POOL_SIZE       = 24;
   localparam int HOLD_CYCLES     = 400;
   localparam int CYCLE_LIMIT     = 2000000;
   localparam logic [2:0] MODE_UNUSED_LO = 3'd6;
   localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [2:0]         req_mode;
   logic signed [31:0] req_value;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [3:0]         rsp_status;
   logic signed [31:0] rsp_entry_value;
   logic [15:0]        rsp_entry_count;
   logic               rsp_last;
   int                 error_count;
   int                 pending_results;

   int                 req_idle_pct = 0;
   int                 rsp_idle_pct = 0;
   int                 hold_requests = 0;
   int                 holds_served = 0;
   int                 hold_left = 0;
   int                 cycle_count = 0;
   logic signed [31:0] value_pool [POOL_SIZE];

   sorted_multiset_table_unit #(
      .DEPTH      (TABLE_DEPTH),
      .COUNT_BITS (COUNT_WIDTH),
      .VALUE_BITS (32)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_entry_value (rsp_entry_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_last        (rsp_last)
   );

   smt_result_checker #(
      .DEPTH      (TABLE_DEPTH),
      .COUNT_BITS (COUNT_WIDTH)
   ) i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_entry_value (rsp_entry_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_last        (rsp_last),
      .error_count     (error_count),
      .pending_results (pending_results)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Response side: random back-pressure, or a long hold when one is requested.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_served) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else begin
            rsp_ready = ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("sorted_multiset_table_unit: mismatch");
      $finish;
   end

   // Offer one item, with random gaps ahead of it; return at its accepting edge.
   task automatic send_op(input logic [2:0] mode, input logic [31:0] value);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_mode  = mode;
      req_value = value;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   // Drop valid and hold until every predicted response item has come back.
   task automatic wait_for_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_results != 0)
         @(negedge clock);
      @(posedge clock);
   endtask

   task automatic refill_pool();
      foreach (value_pool[i]) begin
         case ($urandom_range(7))
            0:       value_pool[i] = 32'sh8000_0000 + $urandom_range(3);
            1:       value_pool[i] = 32'sh7fff_ffff - $urandom_range(3);
            2, 3:    value_pool[i] = $signed($urandom_range(40)) - 20;
            default: value_pool[i] = $urandom;
         endcase
      end
   endtask

   task automatic directed_ops();
      send_op(MODE_READ_ASC, 32'h0);
      send_op(MODE_READ_DESC, 32'hffff_ffff);
      send_op(MODE_REMOVE_MAX, 32'h0);
      send_op(MODE_DELETE, 32'd5);
      send_op(MODE_INSERT, 32'h8000_0000);
      send_op(MODE_INSERT, 32'h7fff_ffff);
      send_op(MODE_INSERT, 32'h0);
      send_op(MODE_INSERT, 32'hffff_ffff);
      send_op(MODE_INSERT, 32'h7fff_ffff);
      send_op(MODE_DELETE, 32'h7fff_ffff);
      send_op(MODE_INSERT, 32'h8000_0000);
      send_op(MODE_READ_ASC, $urandom);
      send_op(MODE_READ_DESC, $urandom);
      send_op(MODE_DELETE, 32'hffff_ffff);
      send_op(MODE_DELETE, 32'd12345);
      send_op(MODE_REMOVE_MAX, $urandom);
      send_op(MODE_UNUSED_LO, $urandom);
      send_op(MODE_UNUSED_HI, $urandom);
      send_op(MODE_READ_ASC, 32'h0);
      send_op(MODE_CLEAR, $urandom);
      send_op(MODE_READ_DESC, 32'h0);
   endtask

   task automatic full_table_ops();
      logic signed [31:0] fill_value [TABLE_DEPTH];
      logic signed [31:0] fresh;
      int k;
      // unique top nibble keeps every fill value distinct
      for (k = 0; k < TABLE_DEPTH; k++)
         fill_value[k] = {(4'(k) ^ 4'h8), 28'($urandom)};
      fresh = {fill_value[3][31:28], fill_value[3][27:0] ^ 28'h1};
      for (k = 0; k < TABLE_DEPTH; k++)
         send_op(MODE_INSERT, fill_value[(k * 5 + 3) % TABLE_DEPTH]);
      send_op(MODE_INSERT, fresh);
      send_op(MODE_INSERT, fill_value[7]);
      send_op(MODE_DELETE, fresh);
      send_op(MODE_READ_ASC, $urandom);
      send_op(MODE_READ_DESC, $urandom);
      send_op(MODE_DELETE, fill_value[7]);
      send_op(MODE_DELETE, fill_value[2]);
      send_op(MODE_INSERT, fresh);
      send_op(MODE_REMOVE_MAX, $urandom);
      send_op(MODE_CLEAR, $urandom);
   endtask

   // Raise one count several times between two neighbors, step it down once, then raise it again.
   task automatic repeat_count_ops();
      logic signed [31:0] rep_value;
      int n;
      rep_value = $urandom;
      send_op(MODE_INSERT, rep_value - 5);
      send_op(MODE_INSERT, rep_value + 5);
      for (n = 0; n < 8; n++)
         send_op(MODE_INSERT, rep_value);
      send_op(MODE_INSERT, rep_value);
      send_op(MODE_DELETE, rep_value);
      send_op(MODE_INSERT, rep_value);
      send_op(MODE_INSERT, rep_value);
      send_op(MODE_READ_ASC, $urandom);
      send_op(MODE_READ_DESC, $urandom);
      send_op(MODE_CLEAR, $urandom);
   endtask

   task automatic send_random_op(output bit effective);
      int pick;
      logic [31:0] operand;
      effective = 1'b1;
      pick = $urandom_range(99);
      operand = value_pool[$urandom_range(POOL_SIZE - 1)];
      if (pick < 40) begin
         if ($urandom_range(4) == 0)
            operand = $urandom;
         send_op(MODE_INSERT, operand);
      end else if (pick < 64) begin
         if ($urandom_range(6) == 0)
            operand = $urandom;
         send_op(MODE_DELETE, operand);
      end else if (pick < 71) begin
         send_op(MODE_REMOVE_MAX, $urandom);
      end else if (pick < 80) begin
         send_op(MODE_READ_ASC, $urandom);
      end else if (pick < 89) begin
         send_op(MODE_READ_DESC, $urandom);
      end else if (pick < 91) begin
         send_op(MODE_CLEAR, $urandom);
      end else if (pick < 94) begin
         send_op($urandom_range(1) ? MODE_UNUSED_HI : MODE_UNUSED_LO, $urandom);
         effective = 1'b0;
      end else if (pick < 96) begin
         wait_for_results();
         effective = 1'b0;
      end else begin
         send_op(MODE_INSERT, $urandom);
      end
   endtask

   task automatic run_random_ops(input int target);
      int done;
      bit effective;
      done = 0;
      while (done < target) begin
         send_random_op(effective);
         if (effective)
            done++;
      end
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_mode  = MODE_INSERT;
      req_value = 32'h0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      req_idle_pct = 9;
      rsp_idle_pct = 51;
      directed_ops();
      full_table_ops();
      refill_pool();
      run_random_ops(105);
      wait_for_results();

      req_idle_pct = 51;
      rsp_idle_pct = 9;
      refill_pool();
      run_random_ops(105);
      wait_for_results();

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      refill_pool();
      hold_requests++;
      // keep offering while responses are held so the input backs up
      run_random_ops(40);
      run_random_ops(66);
      wait_for_results();
      repeat_count_ops();
      wait_for_results();

      repeat (64) @(negedge clock);
      if (error_count == 0 && pending_results == 0)
         $display("sorted_multiset_table_unit: match");
      else
         $display("sorted_multiset_table_unit: mismatch");
      $finish;
   end

endmodule

// File: sorted_multiset_table_unit.f
sv/smt_pkg.sv
sv/smt_ctrl.sv
sv/smt_dp.sv
sv/sorted_multiset_table_unit.sv
verif/smt_result_checker.sv
verif/sorted_multiset_table_unit_test.sv
